>>> design/multi_key_integrator_debouncer_top_defines.svh
// Assertion macros for the key debouncer.
`ifndef MULTI_KEY_INTEGRATOR_DEBOUNCER_TOP_DEFINES_SVH
`define MULTI_KEY_INTEGRATOR_DEBOUNCER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MKID_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("debouncer check failed");
`define MKID_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("debouncer check failed");
`else
`define MKID_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define MKID_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> design/mkid_pkg.sv
// Shared types and constants for the key debouncer.
package mkid_pkg;

  localparam int unsigned RAW_W     = 8;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned PIN_EXT_W = 5;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd10;

  localparam logic KIND_BUTTON = 1'b0;
  localparam logic KIND_SWITCH = 1'b1;
  localparam logic ACT_RELEASE = 1'b0;
  localparam logic ACT_PRESS   = 1'b1;

  typedef struct packed {
    logic load_raw;
    logic step;
    logic push;
    logic push_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic event_hit;
  } dp_sts_t;

endpackage

>>> design/mkid_datapath.sv
// Debouncer datapath: pin counters, stable levels, event hold and output registers.
module mkid_datapath
  import mkid_pkg::*;
#(
  parameter int unsigned NUM_PINS    = 8,
  parameter int unsigned NUM_BUTTONS = 5,
  parameter int unsigned PIN_W       = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 limit_we_i,
  input  logic [CNT_W-1:0]     limit_i,
  input  logic [RAW_W-1:0]     raw_i,
  input  ctrl_cmd_t            cmd_i,
  input  logic [PIN_W-1:0]     pin_i,
  output dp_sts_t              sts_o,
  output logic                 device_kind_o,
  output logic [IDX_W-1:0]     button_index_o,
  output logic                 key_action_o,
  output logic [IDX_W-1:0]     switch_pos_o,
  output logic [MASK_W-1:0]    pressed_mask_o,
  output logic                 last_of_run_o
);

  logic [RAW_W-1:0]  raw_q;
  logic [CNT_W-1:0]  limit_q;
  logic [CNT_W-1:0]  cnt_q [NUM_PINS];
  logic [NUM_PINS-1:0] stable_q;
  logic [MASK_W-1:0] pressed_q;

  logic              hold_kind_q, hold_act_q;
  logic [IDX_W-1:0]  hold_idx_q, hold_pos_q;
  logic [MASK_W-1:0] hold_mask_q;

  logic              out_kind_q, out_act_q, out_last_q;
  logic [IDX_W-1:0]  out_idx_q, out_pos_q;
  logic [MASK_W-1:0] out_mask_q;

  logic [PIN_EXT_W-1:0] pin_ext;
  logic                 active, moved, change, is_btn, ev;
  logic [CNT_W-1:0]     cnt_cur, cnt_nxt;
  logic [MASK_W-1:0]    mask_nxt;
  logic [IDX_W-1:0]     pos_nxt;

  always_comb begin
    pin_ext = PIN_EXT_W'(pin_i);
    active  = (pin_ext < PIN_EXT_W'(RAW_W)) && !raw_q[pin_ext[IDX_W-1:0]];
    cnt_cur = cnt_q[pin_i];
    cnt_nxt = cnt_cur;
    moved   = 1'b0;
    if (active) begin
      if (cnt_cur < limit_q) begin
        cnt_nxt = cnt_cur + CNT_W'(1);
        moved   = 1'b1;
      end
    end else if (cnt_cur != '0) begin
      cnt_nxt = cnt_cur - CNT_W'(1);
      moved   = 1'b1;
    end
    change = !moved && (stable_q[pin_i] != active);
    is_btn = pin_ext < PIN_EXT_W'(NUM_BUTTONS);
    ev     = change && (is_btn || active);
    // only buttons 0..7 live in the mask
    mask_nxt = pressed_q;
    if (change && is_btn && (pin_ext < PIN_EXT_W'(MASK_W))) begin
      mask_nxt[pin_ext[IDX_W-1:0]] = active;
    end
    pos_nxt = IDX_W'(pin_ext - PIN_EXT_W'(NUM_BUTTONS));
  end

  assign sts_o.event_hit = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LIMIT_RESET;
      stable_q  <= '0;
      pressed_q <= '0;
      for (int i = 0; i < NUM_PINS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (limit_we_i) begin
        limit_q <= limit_i;
      end
      if (cmd_i.step) begin
        cnt_q[pin_i] <= cnt_nxt;
        pressed_q    <= mask_nxt;
        if (change) begin
          stable_q[pin_i] <= active;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_raw) begin
      raw_q <= raw_i;
    end
    if (cmd_i.push) begin
      out_kind_q <= hold_kind_q;
      out_idx_q  <= hold_idx_q;
      out_act_q  <= hold_act_q;
      out_pos_q  <= hold_pos_q;
      out_mask_q <= hold_mask_q;
      out_last_q <= cmd_i.push_last;
    end
    if (cmd_i.step && ev) begin
      hold_mask_q <= mask_nxt;
      if (is_btn) begin
        hold_kind_q <= KIND_BUTTON;
        hold_idx_q  <= pin_ext[IDX_W-1:0];
        hold_act_q  <= active ? ACT_PRESS : ACT_RELEASE;
        hold_pos_q  <= '0;
      end else begin
        hold_kind_q <= KIND_SWITCH;
        hold_idx_q  <= '0;
        hold_act_q  <= ACT_PRESS;
        hold_pos_q  <= pos_nxt;
      end
    end
  end

  assign device_kind_o  = out_kind_q;
  assign button_index_o = out_idx_q;
  assign key_action_o   = out_act_q;
  assign switch_pos_o   = out_pos_q;
  assign pressed_mask_o = out_mask_q;
  assign last_of_run_o  = out_last_q;

endmodule

>>> design/mkid_ctrl.sv
// Debouncer controller: request intake, pin scan and event hand-off.
module mkid_ctrl
  import mkid_pkg::*;
#(
  parameter int unsigned NUM_PINS = 8,
  parameter int unsigned PIN_W    = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dp_sts_t          sts_i,
  output ctrl_cmd_t        cmd_o,
  output logic [PIN_W-1:0] pin_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic [PIN_W-1:0] LAST_PIN = PIN_W'(NUM_PINS - 1);

  logic [1:0]       state_q, state_d;
  logic [PIN_W-1:0] pin_q, pin_d;
  logic             hold_valid_q, hold_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free, push_need;

  always_comb begin
    out_free     = !out_valid_q || out_ready_i;
    push_need    = hold_valid_q && sts_i.event_hit;
    state_d      = state_q;
    pin_d        = pin_q;
    hold_valid_d = hold_valid_q;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_raw = 1'b1;
          pin_d          = '0;
          state_d        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // a new event pushes the held one out, so wait for room first
        if (!push_need || out_free) begin
          cmd_o.step = 1'b1;
          cmd_o.push = push_need;
          if (sts_i.event_hit) begin
            hold_valid_d = 1'b1;
          end
          if (pin_q == LAST_PIN) begin
            state_d = ST_FLUSH;
          end else begin
            pin_d = pin_q + PIN_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          hold_valid_d    = 1'b0;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    priority if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pin_q        <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pin_q        <= pin_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign pin_o       = pin_q;

endmodule

>>> design/multi_key_integrator_debouncer_top.sv
// Top level of the multi-key integrator debouncer.
//
// Input channel: one request per tick carries raw_pin_levels_i (active low, a bit per pin).
// Output channel: one result per debounced event, in ascending pin order; last_of_run_o
// marks the final event of a tick. A tick that settles nothing gives no result.
// Config: debounce_limit_we_i writes debounce_limit_i, the saturation value of every
// pin counter; write only while the block is idle.
// Timing: a request is taken in idle, then the scan walks one pin per cycle, unless it
// halts for a stall, through a single shared counter unit, then the flush state ends the
// request. Each event of a tick waits in the hold register until the next event is found
// or the scan reaches the flush state, then moves on into the output register.
// Stall: an event waits in a hold register while the output register is full; the scan
// halts only when a second event needs that hold register.
// Reset: counters, stable levels and the pressed mask clear, the limit returns to 10,
// both channels go idle.
`include "multi_key_integrator_debouncer_top_defines.svh"

module multi_key_integrator_debouncer_top
  import mkid_pkg::*;
#(
  parameter int unsigned NUM_PINS    = 8,
  parameter int unsigned NUM_BUTTONS = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              debounce_limit_we_i,
  input  logic [CNT_W-1:0]  debounce_limit_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [RAW_W-1:0]  raw_pin_levels_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              device_kind_o,
  output logic [IDX_W-1:0]  button_index_o,
  output logic              key_action_o,
  output logic [IDX_W-1:0]  switch_pos_o,
  output logic [MASK_W-1:0] pressed_mask_o,
  output logic              last_of_run_o
);

  localparam int unsigned PIN_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam logic [MASK_W-1:0] BTN_MASK =
    (NUM_BUTTONS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((16'd1 << NUM_BUTTONS) - 16'd1);

  ctrl_cmd_t        cmd;
  dp_sts_t          sts;
  logic [PIN_W-1:0] pin;

  mkid_ctrl #(
    .NUM_PINS (NUM_PINS),
    .PIN_W    (PIN_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .pin_o       (pin)
  );

  mkid_datapath #(
    .NUM_PINS    (NUM_PINS),
    .NUM_BUTTONS (NUM_BUTTONS),
    .PIN_W       (PIN_W)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .limit_we_i     (debounce_limit_we_i),
    .limit_i        (debounce_limit_i),
    .raw_i          (raw_pin_levels_i),
    .cmd_i          (cmd),
    .pin_i          (pin),
    .sts_o          (sts),
    .device_kind_o  (device_kind_o),
    .button_index_o (button_index_o),
    .key_action_o   (key_action_o),
    .switch_pos_o   (switch_pos_o),
    .pressed_mask_o (pressed_mask_o),
    .last_of_run_o  (last_of_run_o)
  );

  `MKID_ASSERT_NEXT(a_scan_blocks_intake, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `MKID_ASSERT_IMPL(a_switch_fields, clk_i, rst_ni, out_valid_o && device_kind_o, key_action_o && button_index_o == '0)
  `MKID_ASSERT_IMPL(a_mask_buttons_only, clk_i, rst_ni, out_valid_o, (pressed_mask_o & ~BTN_MASK) == '0)

endmodule

>>> tb/sv/tb_multi_key_integrator_debouncer_top.sv
// Self-checking testbench for the multi-key integrator debouncer top level.
module tb_multi_key_integrator_debouncer_top
  import mkid_pkg::*;
();

  localparam int unsigned PINS         = 8;
  localparam int unsigned BUTTONS      = 5;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned HOLD_OFF     = 300;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] btn;
    logic             act;
    logic [IDX_W-1:0] sw;
    logic [MASK_W-1:0] mask;
    logic             last;
  } key_event_t;

  // Debounce predictor and store of pending key events
  class key_event_sb;
    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  counts [PINS];
    logic [PINS-1:0]   stable_lv;
    logic [MASK_W-1:0] held_mask;
    logic [IDX_W-1:0]  sw_pos;
    key_event_t        due_q [$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      limit     = LIMIT_RESET;
      stable_lv = '0;
      held_mask = '0;
      sw_pos    = '0;
      errors    = 0;
      checked   = 0;
      foreach (counts[i]) counts[i] = '0;
    endfunction

    function void set_limit(logic [CNT_W-1:0] v);
      limit = v;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    // one tick: integrate every pin, then collect the settled changes in pin order
    function void note_tick(logic [RAW_W-1:0] raw);
      key_event_t run_q [$];
      key_event_t ev;
      logic       lvl;
      logic       moved;
      for (int i = 0; i < PINS; i++) begin
        lvl   = ~raw[i];
        moved = 1'b0;
        if (lvl) begin
          if (counts[i] < limit) begin
            counts[i]++;
            moved = 1'b1;
          end
        end else if (counts[i] != '0) begin
          counts[i]--;
          moved = 1'b1;
        end
        if (!moved && stable_lv[i] != lvl) begin
          stable_lv[i] = lvl;
          if (i < BUTTONS) begin
            held_mask[i] = lvl;
            ev.kind = KIND_BUTTON;
            ev.btn  = IDX_W'(i);
            ev.act  = lvl ? ACT_PRESS : ACT_RELEASE;
            ev.sw   = '0;
            ev.mask = held_mask;
            ev.last = 1'b0;
            run_q.push_back(ev);
          end else if (lvl) begin
            // switch release only moves the stable level
            sw_pos  = IDX_W'(i - BUTTONS);
            ev.kind = KIND_SWITCH;
            ev.btn  = '0;
            ev.act  = ACT_PRESS;
            ev.sw   = sw_pos;
            ev.mask = held_mask;
            ev.last = 1'b0;
            run_q.push_back(ev);
          end
        end
      end
      if (run_q.size() > 0) begin
        ev = run_q.pop_back();
        ev.last = 1'b1;
        run_q.push_back(ev);
      end
      foreach (run_q[k]) due_q.push_back(run_q[k]);
    endfunction

    function void field_diff(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_event(key_event_t got);
      key_event_t want;
      checked++;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected key event, expected none, got %p", $time, got);
        return;
      end
      want = due_q.pop_front();
      field_diff("device_kind", 8'(want.kind), 8'(got.kind));
      field_diff("button_index", 8'(want.btn), 8'(got.btn));
      field_diff("key_action", 8'(want.act), 8'(got.act));
      field_diff("switch_pos", 8'(want.sw), 8'(got.sw));
      field_diff("pressed_mask", 8'(want.mask), 8'(got.mask));
      field_diff("last_of_run", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic              clk_i               = 1'b0;
  logic              rst_ni              = 1'b0;
  logic              debounce_limit_we_i = 1'b0;
  logic [CNT_W-1:0]  debounce_limit_i    = '0;
  logic              in_valid_i          = 1'b0;
  logic              in_ready_o;
  logic [RAW_W-1:0]  raw_pin_levels_i    = '1;
  logic              out_valid_o;
  logic              out_ready_i         = 1'b0;
  logic              device_kind_o;
  logic [IDX_W-1:0]  button_index_o;
  logic              key_action_o;
  logic [IDX_W-1:0]  switch_pos_o;
  logic [MASK_W-1:0] pressed_mask_o;
  logic              last_of_run_o;

  key_event_sb sb = new();

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned ticks_sent  = 0;
  int unsigned events_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned limits_used = 1;
  bit          stall_done  = 1'b0;

  multi_key_integrator_debouncer_top #(
    .NUM_PINS    (PINS),
    .NUM_BUTTONS (BUTTONS)
  ) u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .debounce_limit_we_i (debounce_limit_we_i),
    .debounce_limit_i    (debounce_limit_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .raw_pin_levels_i    (raw_pin_levels_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .device_kind_o       (device_kind_o),
    .button_index_o      (button_index_o),
    .key_action_o        (key_action_o),
    .switch_pos_o        (switch_pos_o),
    .pressed_mask_o      (pressed_mask_o),
    .last_of_run_o       (last_of_run_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // request and event monitors
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_tick(raw_pin_levels_i);
      if (out_valid_o && out_ready_i) begin
        events_seen++;
        sb.check_event('{device_kind_o, button_index_o, key_action_o, switch_pos_o,
                         pressed_mask_o, last_of_run_o});
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("multi_key_integrator_debouncer_top test failed");
        $finish;
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off to fill the block
  initial begin
    forever begin
      @(posedge clk_i);
      if (!stall_done && events_seen >= 40) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
        stall_done = 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_tick(input logic [RAW_W-1:0] raw);
    if (ticks_sent < 125) begin
      tx_idle_pct = 8;
      rx_idle_pct = 52;
    end else if (ticks_sent < 250) begin
      tx_idle_pct = 52;
      rx_idle_pct = 8;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    raw_pin_levels_i <= raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ticks_sent++;
  endtask

  task automatic hold_level(input logic [RAW_W-1:0] raw, input int unsigned n);
    repeat (n) send_tick(raw);
  endtask

  // block idle: all events back, then room for a tick that settles nothing
  task automatic drain();
    in_valid_i <= 1'b0;
    // let the monitor note the request taken at this edge first
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    drain();
    debounce_limit_we_i <= 1'b1;
    debounce_limit_i    <= v;
    @(posedge clk_i);
    debounce_limit_we_i <= 1'b0;
    sb.set_limit(v);
    limits_used++;
  endtask

  // mostly held patterns, often long enough to settle, some single-tick noise
  task automatic drive_random(input int unsigned count);
    int unsigned      done_n;
    int unsigned      span;
    int unsigned      bit_sel;
    logic [RAW_W-1:0] pattern;
    done_n  = 0;
    pattern = '1;
    while (done_n < count) begin
      if ($urandom_range(0, 99) < 15) begin
        send_tick(RAW_W'($urandom));
        done_n++;
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          pattern = RAW_W'($urandom);
        end else begin
          bit_sel = $urandom_range(0, RAW_W - 1);
          pattern[bit_sel] = ~pattern[bit_sel];
        end
        span = $urandom_range(1, int'(sb.limit) + 3);
        if (span > count - done_n) span = count - done_n;
        hold_level(pattern, span);
        done_n += span;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limit: every pin pressed at once, then every pin released
    hold_level(8'h00, 12);
    hold_level(8'hFF, 12);

    write_limit(8'd1);
    drive_random(70);
    write_limit(8'd0);
    drive_random(40);
    write_limit(8'd12);
    drive_random(80);
    hold_level(8'h00, 13);
    // counters now sit above the new limit
    write_limit(8'd3);
    drive_random(60);
    write_limit(8'd255);
    drive_random(40);
    write_limit(8'd5);
    drive_random(50);

    drain();
    $display("Sent %0d ticks over %0d debounce limits (0 and 255 included); checked %0d events.",
             ticks_sent, limits_used, sb.checked);
    if (sb.errors == 0) begin
      $display("multi_key_integrator_debouncer_top test passed");
    end else begin
      $display("multi_key_integrator_debouncer_top test failed");
    end
    $finish;
  end

endmodule
